### design/urlpd_pkg.sv
// Shared types and character constants for the URL percent decoder.
package urlpd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } urlpd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_error;
        logic       end_of_string;
    } urlpd_out_t;

    localparam logic [1:0] PH_PLAIN = 2'd0;
    localparam logic [1:0] PH_HEX1  = 2'd1;
    localparam logic [1:0] PH_HEX2  = 2'd2;

    typedef struct packed {
        logic [1:0] phase;
        logic [3:0] high_nibble;
        logic       discarding;
    } urlpd_state_t;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_NUL     = 8'h00;

endpackage

### design/urlpd_step.sv
// Per-byte decode step: next decoder state and the optional result for one byte.
module urlpd_step (
    input  urlpd_pkg::urlpd_state_t st,
    input  logic                    safe_mode,
    input  urlpd_pkg::urlpd_in_t    item,
    output urlpd_pkg::urlpd_state_t st_next,
    output logic                    res_valid,
    output urlpd_pkg::urlpd_out_t   res
);
    import urlpd_pkg::*;

    logic       hex_ok;
    logic [3:0] hex_val;
    logic [7:0] decoded;
    logic       forbidden;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (item.in_byte >= 8'h30 && item.in_byte <= 8'h39)
        begin
            hex_val = 4'(item.in_byte - 8'h30);
        end
        else if (item.in_byte >= 8'h41 && item.in_byte <= 8'h46)
        begin
            hex_val = 4'(item.in_byte - 8'h37);
        end
        else if (item.in_byte >= 8'h61 && item.in_byte <= 8'h66)
        begin
            hex_val = 4'(item.in_byte - 8'h57);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign decoded   = {st.high_nibble, hex_val};
    assign forbidden = (decoded == CH_SLASH) || (decoded == CH_NUL) || (decoded == CH_DOT)
                    || (decoded == CH_STAR) || (decoded == CH_COLON);

    always_comb
    begin
        st_next   = st;
        res_valid = 1'b0;
        res       = '0;
        if (st.discarding)
        begin
            // drop until the end of the rejected string
            if (item.last)
            begin
                st_next = '0;
            end
        end
        else
        begin
            unique case (st.phase)
                PH_HEX1:
                begin
                    if (!hex_ok || item.last)
                    begin
                        res_valid          = 1'b1;
                        res.is_error       = 1'b1;
                        res.end_of_string  = 1'b1;
                        st_next.phase      = PH_PLAIN;
                        st_next.high_nibble = 4'd0;
                        st_next.discarding = !item.last;
                    end
                    else
                    begin
                        st_next.high_nibble = hex_val;
                        st_next.phase       = PH_HEX2;
                    end
                end
                PH_HEX2:
                begin
                    res_valid         = 1'b1;
                    res.end_of_string = item.last;
                    st_next.phase       = PH_PLAIN;
                    st_next.high_nibble = 4'd0;
                    if (!hex_ok || (safe_mode && forbidden))
                    begin
                        res.is_error       = 1'b1;
                        res.end_of_string  = 1'b1;
                        st_next.discarding = !item.last;
                    end
                    else
                    begin
                        res.out_byte = decoded;
                    end
                end
                default:
                begin
                    if (item.in_byte == CH_PERCENT)
                    begin
                        if (item.last)
                        begin
                            res_valid          = 1'b1;
                            res.is_error       = 1'b1;
                            res.end_of_string  = 1'b1;
                            st_next.phase      = PH_PLAIN;
                            st_next.high_nibble = 4'd0;
                        end
                        else
                        begin
                            st_next.phase = PH_HEX1;
                        end
                    end
                    else
                    begin
                        res_valid         = 1'b1;
                        res.out_byte      = (item.in_byte == CH_PLUS) ? CH_SPACE : item.in_byte;
                        res.end_of_string = item.last;
                        st_next.phase     = PH_PLAIN;
                    end
                end
            endcase
        end
    end

endmodule

### design/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
// Takes one encoded byte per cycle when in_stall is low and gives at most one decoded byte per
// input byte. The input register loads at acceptance and the result register when the decode
// step advances, which an output stall can hold off. A '%' and its first hex digit give no result;
// an error gives one result with is_error and end_of_string set, after which bytes are dropped
// up to the one marked last. Sustained rate is one byte per cycle while out_stall is low, set by
// the single decode step between the two registers. The user must write safe_mode through the
// cfg channel only while no transaction is in flight; the block itself does not enforce this.
module url_percent_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  urlpd_pkg::urlpd_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output urlpd_pkg::urlpd_out_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);
    import urlpd_pkg::*;

    logic         safe_mode_reg;
    logic         s1_valid_reg, s1_valid_next;
    urlpd_in_t    s1_data_reg;
    urlpd_state_t st_reg, st_next;
    logic         out_valid_reg, out_valid_next;
    urlpd_out_t   out_data_reg;
    logic         slot_free;
    logic         advance;
    logic         in_accept;
    logic         res_valid;
    urlpd_out_t   res;

    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && slot_free;
    assign in_stall  = s1_valid_reg && !slot_free;
    assign in_accept = in_valid && !in_stall;

    urlpd_step u_step (
        .st        (st_reg),
        .safe_mode (safe_mode_reg),
        .item      (s1_data_reg),
        .st_next   (st_next),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_mode_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                safe_mode_reg <= cfg_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    // payload registers: load on transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_data;
        end
        if (advance && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### tb/tb.sv
// Self-checking testbench for the URL percent decoder: directed strings, then random ones.
module tb;
    import urlpd_pkg::*;

    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE       = 6;
    localparam int PHASE_ITEMS  = 275;
    localparam int RAND_PHASES  = 6;

    class percent_decode_check;
        bit         safe_mode;
        logic [1:0] phase;
        logic [3:0] high_nib;
        bit         dropping;
        urlpd_out_t decoded_q[$];
        int         fail_count;

        function new();
            safe_mode = 1'b0;
            phase     = PH_PLAIN;
            high_nib  = 4'd0;
            dropping  = 1'b0;
            fail_count = 0;
        endfunction

        // 0..15 for a hex digit, 16 for anything else
        static function logic [4:0] hex_value(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
            if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
            if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
            return 5'd16;
        endfunction

        static function bit forbidden(logic [7:0] b);
            return b == CH_SLASH || b == CH_NUL || b == CH_DOT || b == CH_STAR || b == CH_COLON;
        endfunction

        function void give_byte(logic [7:0] b, logic end_flag);
            urlpd_out_t r;
            r = '{out_byte: b, is_error: 1'b0, end_of_string: end_flag};
            decoded_q.push_back(r);
            phase = PH_PLAIN;
        endfunction

        function void reject(logic lst);
            urlpd_out_t r;
            r = '{out_byte: 8'd0, is_error: 1'b1, end_of_string: 1'b1};
            decoded_q.push_back(r);
            phase    = PH_PLAIN;
            high_nib = 4'd0;
            dropping = !lst;
        endfunction

        function void take_encoded(urlpd_in_t it);
            logic [4:0] hv;
            logic [7:0] v;
            hv = hex_value(it.in_byte);
            if (dropping)
            begin
                if (it.last)
                begin
                    dropping = 1'b0;
                    phase    = PH_PLAIN;
                    high_nib = 4'd0;
                end
                return;
            end
            if (phase == PH_HEX1)
            begin
                if (hv[4] || it.last) reject(it.last);
                else
                begin
                    high_nib = hv[3:0];
                    phase    = PH_HEX2;
                end
            end
            else if (phase == PH_HEX2)
            begin
                v = {high_nib, hv[3:0]};
                if (hv[4]) reject(it.last);
                else if (safe_mode && forbidden(v)) reject(it.last);
                else
                begin
                    high_nib = 4'd0;
                    give_byte(v, it.last);
                end
            end
            else if (it.in_byte == CH_PLUS)
            begin
                give_byte(CH_SPACE, it.last);
            end
            else if (it.in_byte == CH_PERCENT)
            begin
                if (it.last) reject(it.last);
                else phase = PH_HEX1;
            end
            else
            begin
                give_byte(it.in_byte, it.last);
            end
        endfunction

        function void match_decoded(urlpd_out_t got);
            urlpd_out_t want;
            if (decoded_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result byte=%h err=%b end=%b", $time,
                         got.out_byte, got.is_error, got.end_of_string);
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte || got.is_error !== want.is_error ||
                got.end_of_string !== want.end_of_string)
            begin
                fail_count++;
                $display("%0t: mismatch expected byte=%h err=%b end=%b,", $time,
                         want.out_byte, want.is_error, want.end_of_string,
                         " got byte=%h err=%b end=%b",
                         got.out_byte, got.is_error, got.end_of_string);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    urlpd_in_t  in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    urlpd_out_t out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    bit         idle_on = 1'b1;
    bit         long_hold = 1'b0;
    int         quiet = 0;
    logic [7:0] text[$];
    percent_decode_check chk = new();

    url_percent_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Track every transaction on both data channels.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall) chk.match_decoded(out_data);
            if (in_valid && !in_stall) chk.take_encoded(in_data);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("[url_percent_decoder] ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Receiver: random stall bursts, plus one long hold on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (percent_decode_check::hex_value(b) < 5'd16);
        return b;
    endfunction

    task automatic push_encoded(input logic [7:0] b, input logic lst);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, last: lst};
        // hold the transaction until it is taken
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_text();
        foreach (text[i]) push_encoded(text[i], i == text.size() - 1);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (chk.decoded_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_safe_mode(input logic v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        chk.safe_mode = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic make_random_text();
        int         len;
        int         pos;
        int         r;
        logic [7:0] v;
        text.delete();
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                text.push_back(CH_PLUS);
            else if (r < 45)
            begin
                if ($urandom_range(0, 3) == 0)
                    case ($urandom_range(0, 4))
                        0: v = CH_SLASH;
                        1: v = CH_NUL;
                        2: v = CH_DOT;
                        3: v = CH_STAR;
                        default: v = CH_COLON;
                    endcase
                else
                    v = 8'($urandom_range(0, 255));
                text.push_back(CH_PERCENT);
                text.push_back(hex_char(v[7:4]));
                text.push_back(hex_char(v[3:0]));
            end
            else
                text.push_back(8'($urandom_range(1, 255)));
        end
        // break about one string in ten
        if ($urandom_range(0, 9) == 0)
        begin
            pos = $urandom_range(0, text.size());
            case ($urandom_range(0, 3))
                0: text.push_back(CH_PERCENT);
                1:
                begin
                    text.push_back(CH_PERCENT);
                    text.push_back(hex_char(4'($urandom_range(0, 15))));
                end
                2:
                begin
                    text.insert(pos, non_hex());
                    text.insert(pos, CH_PERCENT);
                end
                default:
                begin
                    text.insert(pos, non_hex());
                    text.insert(pos, hex_char(4'($urandom_range(0, 15))));
                    text.insert(pos, CH_PERCENT);
                end
            endcase
        end
    endtask

    initial
    begin
        int phase_items;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // digit-only and lowercase escapes, decoded slash and NUL pass outside safe mode
        text = '{CH_PERCENT, 8'h34, 8'h31, CH_PERCENT, 8'h32, 8'h66, CH_PERCENT, 8'h30, 8'h30};
        send_text();
        text = '{8'hFF, CH_NUL, 8'h01, CH_PLUS};
        send_text();
        // escape cut off after the percent, then after the first digit
        text = '{CH_PERCENT};
        send_text();
        text = '{CH_PERCENT, 8'h34};
        send_text();
        // bad digit, then drop the rest up to the last byte
        text = '{CH_PERCENT, 8'h47, 8'h31, 8'h78};
        send_text();
        settle();

        write_safe_mode(1'b1);
        text = '{CH_PERCENT, 8'h37, 8'h65, CH_PERCENT, 8'h32, 8'h61};
        send_text();
        text = '{CH_PERCENT, 8'h33, 8'h41, 8'h51};
        send_text();
        settle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_safe_mode(p[0] ? 1'b1 : 1'b0);
            if (p == 1) long_hold = 1'b1;
            if (p == RAND_PHASES - 1) idle_on = 1'b0;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                make_random_text();
                send_text();
                phase_items += text.size();
            end
            settle();
        end

        if (chk.fail_count == 0)
            $display("[url_percent_decoder] OK");
        else
            $display("[url_percent_decoder] ERROR");
        $finish;
    end

endmodule
